[sv/assert_macros.svh]
// assertion macros shared by the conv3x3 gaussian/sobel rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_CLK_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/c3gs_pkg.sv]
// shared constants and types for the conv3x3 gaussian/sobel filter
package c3gs_pkg;

    localparam int MAX_SIDE_DEF   = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int SIZE_W     = 11;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE  = 1'b1;

    localparam logic       MODE_GAUSS     = 1'b0;
    localparam logic       MODE_SOBEL     = 1'b1;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd6;
    localparam int         SIDE_MIN       = 3;

    // control that travels with one window column set
    typedef struct packed {
        logic mode;
        logic last;
    } t_item_ctrl;

endpackage

[sv/c3gs_if.sv]
// stream and configuration interfaces of the conv3x3 gaussian/sobel filter
interface c3gs_pix_if #(
    parameter int PIXEL_BITS = c3gs_pkg::PIXEL_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface c3gs_res_if #(
    parameter int PIXEL_BITS = c3gs_pkg::PIXEL_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS+4:0] filtered_value;
    logic                         last_of_frame;

    modport source (output valid, output filtered_value, output last_of_frame, input ready);
    modport sink   (input valid, input filtered_value, input last_of_frame, output ready);
endinterface

interface c3gs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [c3gs_pkg::CFG_IDX_W-1:0]  index;
    logic [c3gs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/c3gs_line_buf.sv]
// two line memories: read on pixel acceptance, written back one stage later
`include "assert_macros.svh"

module c3gs_line_buf #(
    parameter int MAX_SIDE   = c3gs_pkg::MAX_SIDE_DEF,
    parameter int PIXEL_BITS = c3gs_pkg::PIXEL_BITS_DEF,
    localparam int AW        = $clog2(MAX_SIDE)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [PIXEL_BITS-1:0] i_wr_upper,
    input  logic [PIXEL_BITS-1:0] i_wr_middle,
    output logic [PIXEL_BITS-1:0] o_rd_upper,
    output logic [PIXEL_BITS-1:0] o_rd_middle
);

    logic [PIXEL_BITS-1:0] r_mem_upper  [MAX_SIDE];
    logic [PIXEL_BITS-1:0] r_mem_middle [MAX_SIDE];
    logic [PIXEL_BITS-1:0] r_rd_upper;
    logic [PIXEL_BITS-1:0] r_rd_middle;
    logic                  r_rd_live;
    logic                  n_rd_live;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_upper[i_wr_addr]  <= i_wr_upper;
            r_mem_middle[i_wr_addr] <= i_wr_middle;
        end
    end

    // read data holds until the next read, so a stalled stage keeps it
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_upper  <= r_mem_upper[i_rd_addr];
            r_rd_middle <= r_mem_middle[i_rd_addr];
        end
    end

    // a read whose entry has not yet been written back
    always_comb begin
        n_rd_live = r_rd_live;
        if (i_rd_en) begin
            n_rd_live = 1'b1;
        end else if (i_wr_en) begin
            n_rd_live = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_live <= 1'b0;
        end else begin
            r_rd_live <= n_rd_live;
        end
    end

    assign o_rd_upper  = r_rd_upper;
    assign o_rd_middle = r_rd_middle;

    `ASSERT_CLK(a_wb_has_read, i_wr_en |-> r_rd_live, "write-back without a pending read")
    `ASSERT_CLK(a_no_addr_clash, i_rd_en && i_wr_en |-> i_rd_addr != i_wr_addr, "entry clash")

endmodule

[sv/c3gs_kernel.sv]
// kernel sum from three column sums and the output register
`include "assert_macros.svh"

module c3gs_kernel #(
    parameter int PIXEL_BITS = c3gs_pkg::PIXEL_BITS_DEF,
    localparam int CSW       = PIXEL_BITS + 2,
    localparam int OW        = PIXEL_BITS + 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  c3gs_pkg::t_item_ctrl i_ctrl,
    input  logic [CSW-1:0]       i_col_left,
    input  logic [CSW-1:0]       i_col_mid,
    input  logic [CSW-1:0]       i_col_right,
    c3gs_res_if.source           o_res
);

    logic                 r_s2_valid;
    c3gs_pkg::t_item_ctrl r_s2_ctrl;
    logic [CSW-1:0]       r_col_left;
    logic [CSW-1:0]       r_col_mid;
    logic [CSW-1:0]       r_col_right;
    logic                 r_out_valid;
    logic signed [OW-1:0] r_out_value;
    logic                 r_out_last;
    logic                 w_out_free;
    logic                 w_s2_adv;
    logic signed [OW-1:0] w_sum;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_s2_adv   = r_s2_valid && w_out_free;
    assign o_ready    = !r_s2_valid || w_out_free;

    // gaussian weighs columns 1 2 1, sobel takes right minus left
    always_comb begin
        unique case (r_s2_ctrl.mode)
            c3gs_pkg::MODE_GAUSS: begin
                w_sum = OW'(r_col_left) + OW'({r_col_mid, 1'b0}) + OW'(r_col_right);
            end
            c3gs_pkg::MODE_SOBEL: begin
                w_sum = OW'(r_col_right) - OW'(r_col_left);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s2_valid <= i_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s2_ctrl   <= i_ctrl;
            r_col_left  <= i_col_left;
            r_col_mid   <= i_col_mid;
            r_col_right <= i_col_right;
        end
        if (w_s2_adv) begin
            r_out_value <= w_sum;
            r_out_last  <= r_s2_ctrl.last;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.filtered_value = r_out_value;
    assign o_res.last_of_frame  = r_out_last;

    `ASSERT_CLK(a_s2_held, (r_s2_valid && !w_out_free) |=> r_s2_valid, "stalled window sum dropped")

endmodule

[sv/conv3x3_gaussian_sobel.sv]
// 3x3 gaussian/sobel convolution over a raster pixel stream, top level
// throughput: one pixel per cycle while o_res is ready, set by the single read and
//   write-back per line memory entry in each cycle (read on acceptance, written back in
//   the following stage)
// reset: synchronous active low; counters, window and pipeline valids clear, the kernel
//   mode returns to gaussian and the size to 6; line memories are not cleared
`include "assert_macros.svh"

module conv3x3_gaussian_sobel #(
    parameter int MAX_SIDE   = c3gs_pkg::MAX_SIDE_DEF,
    parameter int PIXEL_BITS = c3gs_pkg::PIXEL_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    c3gs_pix_if.sink   i_pix,
    c3gs_res_if.source o_res,
    c3gs_cfg_if.sink   i_cfg
);

    localparam int CW  = $clog2(MAX_SIDE);
    localparam int SW  = (CW + 1 > c3gs_pkg::SIZE_W) ? CW + 1 : c3gs_pkg::SIZE_W;
    localparam int CSW = PIXEL_BITS + 2;

    logic                          r_kernel_mode;
    logic [c3gs_pkg::SIZE_W-1:0]   r_image_size;
    logic [CW-1:0]                 r_col;
    logic [CW-1:0]                 r_row;
    logic [CW-1:0]                 n_col;
    logic [CW-1:0]                 n_row;

    logic                          r_s1_valid;
    logic [PIXEL_BITS-1:0]         r_s1_pixel;
    logic [CW-1:0]                 r_s1_addr;
    logic                          r_s1_produce;
    c3gs_pkg::t_item_ctrl          r_s1_ctrl;
    logic [CSW-1:0]                r_win [3];

    logic [SW-1:0]                 w_size;
    logic [SW-1:0]                 w_side;
    logic [SW-1:0]                 w_last;
    logic                          w_row_end;
    logic                          w_frame_end;
    logic                          w_produce;
    logic                          w_accept;
    logic                          w_s1_adv;
    logic                          w_k_ready;
    logic [PIXEL_BITS-1:0]         w_rd_upper;
    logic [PIXEL_BITS-1:0]         w_rd_middle;
    logic [CSW-1:0]                w_col_new;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_mode <= c3gs_pkg::MODE_GAUSS;
            r_image_size  <= c3gs_pkg::SIZE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                c3gs_pkg::REG_KERNEL_MODE: r_kernel_mode <= i_cfg.data[0];
                c3gs_pkg::REG_IMAGE_SIZE:  r_image_size  <= i_cfg.data;
            endcase
        end
    end

    // clamp side to the supported range
    assign w_size = SW'(r_image_size);

    always_comb begin
        priority if (w_size < SW'(c3gs_pkg::SIDE_MIN)) begin
            w_side = SW'(c3gs_pkg::SIDE_MIN);
        end else if (w_size > SW'(MAX_SIDE)) begin
            w_side = SW'(MAX_SIDE);
        end else begin
            w_side = w_size;
        end
    end

    assign w_last      = w_side - SW'(1);
    assign w_row_end   = SW'(r_col) >= w_last;
    assign w_frame_end = w_row_end && (SW'(r_row) >= w_last);
    assign w_produce   = (r_row >= CW'(2)) && (r_col >= CW'(2));

    // position counters
    assign w_s1_adv    = r_s1_valid && (!r_s1_produce || w_k_ready);
    assign i_pix.ready = !r_s1_valid || w_s1_adv;
    assign w_accept    = i_pix.valid && i_pix.ready;

    always_comb begin
        n_col = r_col + CW'(1);
        n_row = r_row;
        if (w_row_end) begin
            n_col = '0;
            n_row = w_frame_end ? '0 : r_row + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_pix.ready) begin
                r_s1_valid <= i_pix.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pixel     <= i_pix.pixel;
            r_s1_addr      <= r_col;
            r_s1_produce   <= w_produce;
            r_s1_ctrl.mode <= r_kernel_mode;
            r_s1_ctrl.last <= w_frame_end;
        end
    end

    c3gs_line_buf #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_accept),
        .i_rd_addr   (r_col),
        .i_wr_en     (w_s1_adv),
        .i_wr_addr   (r_s1_addr),
        .i_wr_upper  (w_rd_middle),
        .i_wr_middle (r_s1_pixel),
        .o_rd_upper  (w_rd_upper),
        .o_rd_middle (w_rd_middle)
    );

    // window kept as weighted column sums: top + 2*middle + bottom
    assign w_col_new = CSW'(w_rd_upper) + CSW'({w_rd_middle, 1'b0})
                     + CSW'(r_s1_pixel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= '0;
            r_win[1] <= '0;
            r_win[2] <= '0;
        end else if (w_s1_adv) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= w_col_new;
        end
    end

    c3gs_kernel #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_kernel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_s1_adv && r_s1_produce),
        .o_ready     (w_k_ready),
        .i_ctrl      (r_s1_ctrl),
        .i_col_left  (r_win[1]),
        .i_col_mid   (r_win[2]),
        .i_col_right (w_col_new),
        .o_res       (o_res)
    );

    `ASSERT_CLK_RST(a_rst_no_result, !i_rst_n |=> !o_res.valid, "result valid right after reset")

endmodule
